>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define BSM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BSM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/bsm_pkg.sv
`timescale 1ns / 1ps

package bsm_pkg;

  localparam int BANK_REG_COUNT = 8;
  localparam int BANK_IDX_W     = $clog2(BANK_REG_COUNT);

  localparam int OP_W     = 2;
  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int BANK_W   = 8;
  localparam int COUNT_W  = 7;

  localparam int IN_TDATA_W  = 24;   // addr, data
  localparam int IN_TUSER_W  = 8;    // op, zero filled
  localparam int OUT_TDATA_W = 16;   // bank, bank_is_ram, mapped, mirror, irq, zero filled

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;

  // item kinds
  localparam logic [OP_W-1:0] OP_CPU_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_CPU_XLATE = 2'd1;
  localparam logic [OP_W-1:0] OP_PPU_XLATE = 2'd2;
  localparam logic [OP_W-1:0] OP_A12_RISE  = 2'd3;

  // register decode on addr & DECODE_MASK
  localparam logic [ADDR_W-1:0] DECODE_MASK     = 16'hE001;
  localparam logic [ADDR_W-1:0] REG_BANK_SELECT = 16'h8000;
  localparam logic [ADDR_W-1:0] REG_BANK_DATA   = 16'h8001;
  localparam logic [ADDR_W-1:0] REG_MIRROR      = 16'hA000;
  localparam logic [ADDR_W-1:0] REG_IRQ_LATCH   = 16'hC000;
  localparam logic [ADDR_W-1:0] REG_IRQ_RELOAD  = 16'hC001;
  localparam logic [ADDR_W-1:0] REG_IRQ_DISABLE = 16'hE000;
  localparam logic [ADDR_W-1:0] REG_IRQ_ENABLE  = 16'hE001;

  localparam logic [BANK_IDX_W-1:0] PRG_REG_A = 3'd6;
  localparam logic [BANK_IDX_W-1:0] PRG_REG_B = 3'd7;
  localparam logic [BANK_IDX_W-1:0] CHR_1K_BASE = 3'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PRG_BANK_COUNT = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CART_MIRROR    = 8'd1;

  localparam logic [COUNT_W-1:0] PRG_BANK_COUNT_RESET = 7'd32;
  localparam logic               CART_MIRROR_RESET    = 1'b0;

  typedef struct packed {
    logic              irq_line;
    logic              mirror_horizontal;
    logic              mapped;
    logic              bank_is_ram;
    logic [BANK_W-1:0] bank;
  } res_t;

  localparam int RES_W = $bits(res_t);

endpackage

>>> hw/rtl/bank_switch_mapper_scanline_irq.sv
`timescale 1ns / 1ps

// Bank-switching cartridge mapper with a scanline interrupt counter. Each input word is
// a CPU register write, a CPU or PPU address to translate, or an already filtered A12
// rise; every word gives exactly one result word carrying the bank, the RAM and mapped
// flags, and the mirroring and IRQ levels as they stand after that word. One word is
// taken per clock while the skid buffer is empty, and its result is registered: the whole
// decode, translate and counter update sits between the input handshake and the output
// register; a one-word skid buffer keeps input accepting for one word while output stalls.
// Configuration writes are accepted in any cycle and belong between bursts of traffic.
module bank_switch_mapper_scanline_irq import bsm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,

  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // addr[15:0], data[23:16]
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // op[1:0], zeros

  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // bank[7:0], bank_is_ram, mapped,
                                                 // mirror_horizontal, irq_line, zeros

  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [COUNT_W-1:0]    prg_bank_count;

  logic [BANK_IDX_W-1:0] select_index, select_index_next;
  logic [BANK_W-1:0]     bank_regs [BANK_REG_COUNT];
  logic                  prg_swap_mode, prg_swap_mode_next;
  logic                  chr_invert_mode, chr_invert_mode_next;
  logic [7:0]            irq_latch, irq_latch_next;
  logic [7:0]            irq_count, irq_count_next;
  logic                  reload_pending, reload_pending_next;
  logic                  irq_enabled, irq_enabled_next;
  logic                  irq_asserted, irq_asserted_next;
  logic                  mirror_state, mirror_state_next;
  logic                  bank_wr;

  logic                  out_valid, skid_valid;
  res_t                  out_res, skid_res, res;

  logic [OP_W-1:0]       op;
  logic [ADDR_W-1:0]     addr;
  logic [DATA_W-1:0]     data;
  logic [ADDR_W-1:0]     key;
  logic                  in_acc, cfg_acc;
  logic [BANK_W-1:0]     last_bank, second_bank;
  logic                  chr_high;

  assign op   = s_axis_tuser[OP_W-1:0];
  assign addr = s_axis_tdata[ADDR_W-1:0];
  assign data = s_axis_tdata[ADDR_W +: DATA_W];
  assign key  = addr & DECODE_MASK;

  assign s_axis_tready = !skid_valid;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign cfg_acc       = cfg_valid && cfg_ready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, out_res};

  assign last_bank   = {1'b0, prg_bank_count} - 8'd1;
  assign second_bank = {1'b0, prg_bank_count} - 8'd2;
  assign chr_high    = addr[12] ^ chr_invert_mode;

  always_comb begin
    select_index_next    = select_index;
    prg_swap_mode_next   = prg_swap_mode;
    chr_invert_mode_next = chr_invert_mode;
    irq_latch_next       = irq_latch;
    irq_count_next       = irq_count;
    reload_pending_next  = reload_pending;
    irq_enabled_next     = irq_enabled;
    irq_asserted_next    = irq_asserted;
    mirror_state_next    = mirror_state;
    bank_wr              = 1'b0;
    res                  = '0;

    unique case (op)
      OP_CPU_WRITE: begin
        if (addr[15]) begin
          unique case (key)
            REG_BANK_SELECT: begin
              select_index_next    = data[BANK_IDX_W-1:0];
              prg_swap_mode_next   = data[6];
              chr_invert_mode_next = data[7];
            end
            REG_BANK_DATA:   bank_wr = 1'b1;
            REG_MIRROR:      mirror_state_next = data[0];
            REG_IRQ_LATCH:   irq_latch_next = data;
            REG_IRQ_RELOAD: begin
              irq_count_next      = '0;
              reload_pending_next = 1'b1;
            end
            REG_IRQ_DISABLE: begin
              irq_enabled_next  = 1'b0;
              irq_asserted_next = 1'b0;
            end
            REG_IRQ_ENABLE:  irq_enabled_next = 1'b1;
            default: ;
          endcase
        end
      end
      OP_CPU_XLATE: begin
        if (addr[15:13] == 3'b011) begin
          res.bank_is_ram = 1'b1;
          res.mapped      = 1'b1;
        end else if (addr[15]) begin
          res.mapped = 1'b1;
          unique case (addr[14:13])
            2'd0:    res.bank = prg_swap_mode ? second_bank : bank_regs[PRG_REG_A];
            2'd1:    res.bank = bank_regs[PRG_REG_B];
            2'd2:    res.bank = prg_swap_mode ? bank_regs[PRG_REG_A] : second_bank;
            default: res.bank = last_bank;
          endcase
        end
      end
      OP_PPU_XLATE: begin
        if (addr[15:13] == 3'b000) begin
          res.mapped = 1'b1;
          if (!chr_high) begin
            // 2K window: even bank, low bit from address bit 10
            res.bank = {bank_regs[{2'b00, addr[11]}][BANK_W-1:1], addr[10]};
          end else begin
            res.bank = bank_regs[CHR_1K_BASE + {1'b0, addr[11:10]}];
          end
        end
      end
      default: begin
        if (irq_count == '0 || reload_pending) begin
          irq_count_next = irq_latch;
        end else begin
          irq_count_next = irq_count - 8'd1;
        end
        if (irq_count_next == '0 && irq_enabled) begin
          irq_asserted_next = 1'b1;
        end
        reload_pending_next = 1'b0;
      end
    endcase

    res.mirror_horizontal = mirror_state_next;
    res.irq_line          = irq_asserted_next;
  end

  // mapper state
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count         <= PRG_BANK_COUNT_RESET;
      select_index           <= '0;
      prg_swap_mode          <= 1'b0;
      chr_invert_mode        <= 1'b0;
      irq_latch              <= '0;
      irq_count              <= '0;
      reload_pending         <= 1'b0;
      irq_enabled            <= 1'b0;
      irq_asserted           <= 1'b0;
      mirror_state           <= CART_MIRROR_RESET;
      for (int i = 0; i < BANK_REG_COUNT; i++) begin
        bank_regs[i] <= '0;
      end
    end else begin
      if (in_acc) begin
        select_index    <= select_index_next;
        prg_swap_mode   <= prg_swap_mode_next;
        chr_invert_mode <= chr_invert_mode_next;
        irq_latch       <= irq_latch_next;
        irq_count       <= irq_count_next;
        reload_pending  <= reload_pending_next;
        irq_enabled     <= irq_enabled_next;
        irq_asserted    <= irq_asserted_next;
        mirror_state    <= mirror_state_next;
        if (bank_wr) begin
          bank_regs[select_index] <= data;
        end
      end
      if (cfg_acc) begin
        if (cfg_index == CFG_PRG_BANK_COUNT) begin
          prg_bank_count <= cfg_data[COUNT_W-1:0];
        end else if (cfg_index == CFG_CART_MIRROR) begin
          // header mirroring only matters through the live mirror state
          mirror_state <= cfg_data[0];
        end
      end
    end
  end

  // output register plus one-word skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      out_valid  <= skid_valid || in_acc;
      skid_valid <= 1'b0;
    end else if (in_acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (in_acc) begin
      skid_res <= res;
    end
  end

endmodule

>>> hw/rtl/bsm_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsm_checker import bsm_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  res_t obs;
  assign obs = res_t'(m_axis_tdata[RES_W-1:0]);

  `BSM_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_axis_tvalid, "output valid right after reset")

  `BSM_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "stalled output word dropped")

  `BSM_ASSERT(a_empty_fill, clk, rst, s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> m_axis_tvalid, "accepted word did not reach empty output")

  `BSM_ASSERT(a_skid_full, clk, rst, s_axis_tvalid && s_axis_tready && m_axis_tvalid && !m_axis_tready |=> !s_axis_tready, "input still ready with skid word held")

  `BSM_ASSERT(a_unmapped_zero, clk, rst, m_axis_tvalid && !obs.mapped |-> obs.bank == '0 && !obs.bank_is_ram, "unmapped word carries a bank")

endmodule

bind bank_switch_mapper_scanline_irq bsm_checker u_bsm_checker (.*);

>>> dv/tb_bank_switch_mapper_scanline_irq.sv
`timescale 1ns / 1ps

module tb_bank_switch_mapper_scanline_irq;
  import bsm_pkg::*;

  localparam logic [ADDR_W-1:0] PRG_RAM_BASE = 16'h6000;
  localparam logic [ADDR_W-1:0] PRG_ROM_BASE = 16'h8000;
  localparam logic [ADDR_W-1:0] CHR_END      = 16'h2000;
  localparam logic [ADDR_W-1:0] CHR_HALF_BIT = 16'h1000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS    = 210;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } bus_word_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // addr[15:0], data[23:16]
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;   // op[1:0], zeros
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // bank[7:0], bank_is_ram, mapped,
                                               // mirror_horizontal, irq_line, zeros
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  bank_switch_mapper_scanline_irq dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // mapper shadow state
  logic [COUNT_W-1:0]    prg_banks;
  logic [BANK_IDX_W-1:0] sel_idx;
  logic [BANK_W-1:0]     bank_reg [BANK_REG_COUNT];
  logic                  prg_swap, chr_invert;
  logic [7:0]            irq_reload_val, irq_counter;
  logic                  reload_req, irq_en, irq_flag, mirror_q;

  bus_word_t bus_q[$];
  res_t      want_res_q[$];
  int        n_queued = 0;
  int        n_accepted = 0;
  int        n_errors = 0;
  int        src_idle_pct = 13;
  int        dst_idle_pct = 64;
  bit        rx_hold = 1'b0;
  bit        stall_go = 1'b0;
  logic      in_fire = 1'b0;

  function automatic res_t mapper_step(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                       logic [DATA_W-1:0] data);
    res_t r;
    logic [ADDR_W-1:0] v;
    logic [BANK_W-1:0] last_bank, second_bank;
    r = '0;
    last_bank   = {1'b0, prg_banks} - 8'd1;
    second_bank = {1'b0, prg_banks} - 8'd2;
    case (op)
      OP_CPU_WRITE: begin
        if (addr >= PRG_ROM_BASE) begin
          case (addr & DECODE_MASK)
            REG_BANK_SELECT: begin
              sel_idx    = data[2:0];
              prg_swap   = data[6];
              chr_invert = data[7];
            end
            REG_BANK_DATA:   bank_reg[sel_idx] = data;
            REG_MIRROR:      mirror_q = data[0];
            REG_IRQ_LATCH:   irq_reload_val = data;
            REG_IRQ_RELOAD: begin
              irq_counter = '0;
              reload_req  = 1'b1;
            end
            REG_IRQ_DISABLE: begin
              irq_en   = 1'b0;
              irq_flag = 1'b0;
            end
            REG_IRQ_ENABLE:  irq_en = 1'b1;
            default: ;
          endcase
        end
      end
      OP_CPU_XLATE: begin
        if (addr >= PRG_ROM_BASE) begin
          r.mapped = 1'b1;
          case (addr[14:13])
            2'd0:    r.bank = prg_swap ? second_bank : bank_reg[PRG_REG_A];
            2'd1:    r.bank = bank_reg[PRG_REG_B];
            2'd2:    r.bank = prg_swap ? bank_reg[PRG_REG_A] : second_bank;
            default: r.bank = last_bank;
          endcase
        end else if (addr >= PRG_RAM_BASE) begin
          r.bank_is_ram = 1'b1;
          r.mapped      = 1'b1;
        end
      end
      OP_PPU_XLATE: begin
        if (addr < CHR_END) begin
          v = addr ^ (chr_invert ? CHR_HALF_BIT : '0);
          r.mapped = 1'b1;
          // 2K windows force the even bank and take A10 as the low bit
          if (!v[12])
            r.bank = (bank_reg[{2'b00, v[11]}] & 8'hFE) | {7'd0, v[10]};
          else
            r.bank = bank_reg[CHR_1K_BASE + {1'b0, v[11:10]}];
        end
      end
      default: begin
        if (irq_counter == 8'd0 || reload_req)
          irq_counter = irq_reload_val;
        else
          irq_counter = irq_counter - 8'd1;
        if (irq_counter == 8'd0 && irq_en)
          irq_flag = 1'b1;
        reload_req = 1'b0;
      end
    endcase
    r.mirror_horizontal = mirror_q;
    r.irq_line          = irq_flag;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endfunction

  // driver: input changes at the falling edge, a word stays put until taken
  always @(negedge clk) begin
    bus_word_t w;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (bus_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        w = bus_q.pop_front();
        s_axis_tdata  <= {w.data, w.addr};
        s_axis_tuser  <= {{(IN_TUSER_W-OP_W){1'b0}}, w.op};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= dst_idle_pct);
  end

  // long output back-pressure, started once by the stimulus
  initial begin
    wait (stall_go);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  // monitor: check the output word first, then predict the word taken this edge
  always @(posedge clk) begin
    res_t got, want;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[RES_W-1:0];
        if (want_res_q.size() == 0) begin
          $error("result word %0h with nothing pending", got);
          n_errors++;
        end else begin
          want = want_res_q.pop_front();
          check_field("bank", want.bank, got.bank);
          check_field("bank_is_ram", {7'd0, want.bank_is_ram}, {7'd0, got.bank_is_ram});
          check_field("mapped", {7'd0, want.mapped}, {7'd0, got.mapped});
          check_field("mirror_horizontal", {7'd0, want.mirror_horizontal},
                      {7'd0, got.mirror_horizontal});
          check_field("irq_line", {7'd0, want.irq_line}, {7'd0, got.irq_line});
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want_res_q.push_back(mapper_step(s_axis_tuser[OP_W-1:0], s_axis_tdata[ADDR_W-1:0],
                                         s_axis_tdata[ADDR_W +: DATA_W]));
        n_accepted++;
      end
    end
  end

  task automatic push_word(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                           logic [DATA_W-1:0] data);
    bus_word_t w;
    w.op   = op;
    w.addr = addr;
    w.data = data;
    bus_q.push_back(w);
    n_queued++;
  endtask

  // register address with random don't-care bits, so aliases get hit too
  function automatic logic [ADDR_W-1:0] reg_addr(logic [ADDR_W-1:0] code);
    return (ADDR_W'($urandom) & ~DECODE_MASK) | code;
  endfunction

  task automatic push_xlate();
    if ($urandom_range(1))
      push_word(OP_CPU_XLATE, ADDR_W'($urandom), DATA_W'($urandom));
    else if ($urandom_range(3) != 0)
      push_word(OP_PPU_XLATE, ADDR_W'($urandom_range(CHR_END - 1)), DATA_W'($urandom));
    else
      push_word(OP_PPU_XLATE, ADDR_W'($urandom), DATA_W'($urandom));
  endtask

  task automatic push_burst();
    int kind, n;
    logic [DATA_W-1:0] lat;
    kind = $urandom_range(9);
    if (kind < 3) begin
      push_word(OP_CPU_WRITE, reg_addr(REG_BANK_SELECT), DATA_W'($urandom));
      push_word(OP_CPU_WRITE, reg_addr(REG_BANK_DATA), DATA_W'($urandom));
      push_xlate();
      push_xlate();
    end else if (kind < 5) begin
      // program the scanline counter, then clock it
      lat = ($urandom_range(3) == 0) ? DATA_W'($urandom) : DATA_W'($urandom_range(4));
      push_word(OP_CPU_WRITE, reg_addr(REG_IRQ_LATCH), lat);
      if ($urandom_range(1))
        push_word(OP_CPU_WRITE, reg_addr(REG_IRQ_RELOAD), DATA_W'($urandom));
      push_word(OP_CPU_WRITE,
                reg_addr(($urandom_range(3) != 0) ? REG_IRQ_ENABLE : REG_IRQ_DISABLE),
                DATA_W'($urandom));
      n = $urandom_range(1, 10);
      repeat (n) begin
        push_word(OP_A12_RISE, ADDR_W'($urandom), DATA_W'($urandom));
        case ($urandom_range(9))
          0: push_word(OP_CPU_WRITE, reg_addr(REG_IRQ_DISABLE), DATA_W'($urandom));
          1: push_word(OP_CPU_WRITE, reg_addr(REG_IRQ_RELOAD), DATA_W'($urandom));
          2: push_word(OP_CPU_WRITE, reg_addr(REG_IRQ_ENABLE), DATA_W'($urandom));
          3, 4: push_xlate();
          default: ;
        endcase
      end
    end else if (kind < 6) begin
      push_word(OP_CPU_WRITE, reg_addr(REG_MIRROR), DATA_W'($urandom));
      push_xlate();
    end else if (kind < 9) begin
      push_xlate();
    end else begin
      push_word(OP_W'($urandom), ADDR_W'($urandom), DATA_W'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || want_res_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_PRG_BANK_COUNT) begin
      prg_banks = val[COUNT_W-1:0];
    end else if (idx == CFG_CART_MIRROR) begin
      mirror_q = val[0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] banks, logic [CFG_DATA_W-1:0] mirror,
                           bit hold_rx);
    int target;
    write_cfg(CFG_PRG_BANK_COUNT, banks);
    write_cfg(CFG_CART_MIRROR, mirror);
    target = n_queued + PHASE_ITEMS;
    while (n_queued < target) push_burst();
    if (hold_rx) stall_go = 1'b1;
    // sender waits here until every result is back
    wait_drained();
  endtask

  initial begin
    prg_banks      = PRG_BANK_COUNT_RESET;
    sel_idx        = '0;
    foreach (bank_reg[i]) bank_reg[i] = '0;
    prg_swap       = 1'b0;
    chr_invert     = 1'b0;
    irq_reload_val = '0;
    irq_counter    = '0;
    reload_req     = 1'b0;
    irq_en         = 1'b0;
    irq_flag       = 1'b0;
    mirror_q       = CART_MIRROR_RESET;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset state, window edges, every register, counter corners
    push_word(OP_CPU_XLATE, 16'h0000, 8'h00);
    push_word(OP_CPU_XLATE, 16'h5FFF, 8'hFF);
    push_word(OP_CPU_XLATE, 16'h6000, 8'h00);
    push_word(OP_CPU_XLATE, 16'h7FFF, 8'h00);
    push_word(OP_CPU_XLATE, 16'hFFFF, 8'h00);
    push_word(OP_PPU_XLATE, 16'h1FFF, 8'h00);
    push_word(OP_PPU_XLATE, 16'h2000, 8'h00);
    push_word(OP_CPU_WRITE, 16'h7FFF, 8'hFF);                  // below register space
    push_word(OP_CPU_WRITE, REG_BANK_SELECT | 16'h1FFE, 8'hC6); // swap + invert, reg 6
    push_word(OP_CPU_WRITE, REG_BANK_DATA, 8'hFF);
    push_word(OP_CPU_XLATE, 16'h8000, 8'h00);
    push_word(OP_CPU_XLATE, 16'hC000, 8'h00);
    push_word(OP_CPU_WRITE, REG_BANK_SELECT, 8'h00);
    push_word(OP_CPU_WRITE, REG_BANK_DATA, 8'hFF);
    push_word(OP_PPU_XLATE, 16'h0400, 8'h00);
    push_word(OP_CPU_WRITE, REG_MIRROR, 8'hFF);
    push_word(OP_CPU_WRITE, REG_MIRROR | 16'h0001, 8'h00);     // ignored register
    push_word(OP_CPU_WRITE, REG_IRQ_LATCH, 8'h00);
    push_word(OP_CPU_WRITE, REG_IRQ_ENABLE, 8'h00);
    push_word(OP_A12_RISE, 16'hFFFF, 8'hFF);
    push_word(OP_CPU_WRITE, REG_IRQ_LATCH, 8'h02);
    push_word(OP_CPU_WRITE, REG_IRQ_RELOAD, 8'h00);
    push_word(OP_A12_RISE, 16'h0000, 8'h00);
    push_word(OP_A12_RISE, 16'h0000, 8'h00);
    push_word(OP_A12_RISE, 16'h0000, 8'h00);
    push_word(OP_CPU_WRITE, REG_IRQ_DISABLE, 8'h00);
    wait_drained();

    run_phase(8'd2, 8'h01, 1'b1);
    run_phase(8'd64, 8'hFE, 1'b0);

    src_idle_pct = 64;
    dst_idle_pct = 13;
    run_phase(8'h81, 8'h01, 1'b0);
    run_phase(8'h00, CFG_DATA_W'($urandom), 1'b0);

    src_idle_pct = 0;
    dst_idle_pct = 0;
    run_phase(8'hFF, 8'h01, 1'b0);
    run_phase(CFG_DATA_W'($urandom_range(2, 64)), CFG_DATA_W'($urandom), 1'b0);

    repeat (10) @(negedge clk);
    if (n_errors == 0 && want_res_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/bsm_pkg.sv
hw/rtl/bank_switch_mapper_scanline_irq.sv
hw/rtl/bsm_checker.sv
dv/tb_bank_switch_mapper_scanline_irq.sv
